// File: rtl/ips_pkg.sv
package ips_pkg;

  localparam int DATA_W     = 16;
  localparam int COORD_W    = 16;
  localparam int POS_W      = 6;
  localparam int DIM_W      = 7;
  localparam int RAD_W      = 2;
  localparam int OFS_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_RADIUS = 2'd3;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 7'd64;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 7'd64;
  localparam logic             RST_INTERP_MODE  = 1'b1;
  localparam logic [RAD_W-1:0] RST_PATCH_RADIUS = 2'd0;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [POS_W-1:0]          write_col;
    logic [POS_W-1:0]          write_row;
    logic [DATA_W-1:0]         write_value;
    logic                      wr_ok;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             interp_mode;
    logic [RAD_W-1:0] patch_radius;
  } cfg_t;

endpackage

// File: rtl/ips_in_if.sv
interface ips_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       req_type;
  logic signed [ips_pkg::COORD_W-1:0]         x_coord;
  logic signed [ips_pkg::COORD_W-1:0]         y_coord;
  logic [ips_pkg::POS_W-1:0]                  write_col;
  logic [ips_pkg::POS_W-1:0]                  write_row;
  logic [ips_pkg::DATA_W-1:0]                 write_value;

  modport source (
    output valid, req_type, x_coord, y_coord, write_col, write_row, write_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_coord, y_coord, write_col, write_row, write_value,
    output ready
  );
endinterface

// File: rtl/ips_out_if.sv
interface ips_out_if;
  logic                        valid;
  logic                        ready;
  logic [ips_pkg::DATA_W-1:0]  sample_value;
  logic                        last_sample;

  modport source (
    output valid, sample_value, last_sample,
    input  ready
  );
  modport sink (
    input  valid, sample_value, last_sample,
    output ready
  );
endinterface

// File: rtl/image_patch_sampler.sv
// Image patch sampler.
// items (sink): req_type 0 stores write_value at (write_row, write_col) and gives
//   no result; positions beyond MAX_WIDTH/MAX_HEIGHT are dropped. req_type 1
//   samples a (2r+1)^2 patch around (x_coord, y_coord), signed Q.FRAC_BITS.
// results (source): one sample_value per patch offset, rows outer, columns
//   inner; last_sample marks the final one.
// cfg_we/cfg_index/cfg_data write image_width, image_height, interp_mode and
//   patch_radius; write them only while no transaction is in flight.
// Items go through a two-entry queue to the sequencer, which owns the pixel
//   store. A write is stored as it leaves the queue. A sample leaves the
//   queue, then each bilinear result takes an index step, four store reads,
//   four multiply/accumulate steps and emit; each nearest result takes an
//   index step, two reads and emit.
// When results stalls, the sequencer holds in its emit step; the queue keeps
//   accepting until it holds two items.
// Reset (rst, synchronous) restores register defaults (64, 64, bilinear,
//   radius 0) and empties queue and output; pixel contents are not cleared.
module image_patch_sampler #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int FRAC_BITS  = 8,
  parameter int MAX_RADIUS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ips_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ips_pkg::CFG_DATA_W-1:0]    cfg_data,
  ips_in_if.sink                            items,
  ips_out_if.source                         results
);

  ips_pkg::cfg_t   cfg;
  logic            q_full;
  logic            q_push;
  ips_pkg::item_t  q_in;
  logic            q_valid;
  logic            q_pop;
  ips_pkg::item_t  q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= ips_pkg::RST_IMAGE_WIDTH;
      cfg.image_height <= ips_pkg::RST_IMAGE_HEIGHT;
      cfg.interp_mode  <= ips_pkg::RST_INTERP_MODE;
      cfg.patch_radius <= ips_pkg::RST_PATCH_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        ips_pkg::CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        ips_pkg::CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        ips_pkg::CFG_INTERP_MODE:  cfg.interp_mode  <= cfg_data[0];
        ips_pkg::CFG_PATCH_RADIUS: cfg.patch_radius <= cfg_data[ips_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  ips_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .items  (items),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  ips_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  ips_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

// File: rtl/ips_front.sv
module ips_front #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  ips_in_if.sink          items,
  input  logic            q_full,
  output logic            q_push,
  output ips_pkg::item_t  q_item
);

  assign items.ready = !q_full;
  assign q_push      = items.valid && !q_full;

  always_comb begin
    q_item.req_type    = items.req_type;
    q_item.x_coord     = items.x_coord;
    q_item.y_coord     = items.y_coord;
    q_item.write_col   = items.write_col;
    q_item.write_row   = items.write_row;
    q_item.write_value = items.write_value;
    // writes outside the store are dropped
    q_item.wr_ok = (items.req_type == ips_pkg::REQ_WRITE) &&
                   (32'(items.write_col) < MAX_WIDTH) &&
                   (32'(items.write_row) < MAX_HEIGHT);
  end

endmodule

// File: rtl/ips_queue.sv
module ips_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ips_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ips_pkg::item_t  head
);

  ips_pkg::item_t                slots [ips_pkg::Q_DEPTH];
  logic [ips_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [ips_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [ips_pkg::Q_CNT_W-1:0]   count;

  function automatic logic [ips_pkg::Q_PTR_W-1:0] ptr_inc(
    input logic [ips_pkg::Q_PTR_W-1:0] p
  );
    if (p == ips_pkg::Q_PTR_W'(ips_pkg::Q_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  assign full  = (count == ips_pkg::Q_CNT_W'(ips_pkg::Q_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      count <= count + ips_pkg::Q_CNT_W'(push) - ips_pkg::Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// File: rtl/ips_back.sv
module ips_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int FRAC_BITS  = 8,
  parameter int MAX_RADIUS = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  ips_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  ips_pkg::item_t  q_item,
  output logic            q_pop,
  ips_out_if.source       results
);

  localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int IW        = (XW > YW) ? XW : YW;
  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MW        = $clog2(MEM_DEPTH);
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE / 2;
  localparam int RND_POS   = 2 * FRAC_BITS;
  localparam int RND_HALF  = 1 << (RND_POS - 1);
  localparam int PW        = $clog2(32768 + MAX_RADIUS * ONE + 1) + 1;
  localparam int FXW       = $clog2(32768 + (MAX_RADIUS + MAX_DIM) * ONE) + 1;
  localparam int PDW       = ips_pkg::DATA_W + 1;
  localparam int PLW       = PDW + FXW;
  localparam int AW        = PLW + 1;
  localparam int DW        = AW + 1;
  localparam int HW        = DW - 16;
  localparam int PHW       = HW + FXW;
  localparam int ACW       = DW + FXW + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_IDX  = 4'd1;
  localparam logic [3:0] ST_RD0  = 4'd2;
  localparam logic [3:0] ST_RD1  = 4'd3;
  localparam logic [3:0] ST_RD2  = 4'd4;
  localparam logic [3:0] ST_RD3  = 4'd5;
  localparam logic [3:0] ST_MUL1 = 4'd6;
  localparam logic [3:0] ST_DIFF = 4'd7;
  localparam logic [3:0] ST_MUL2 = 4'd8;
  localparam logic [3:0] ST_ACC  = 4'd9;
  localparam logic [3:0] ST_EMIT = 4'd10;

  logic [3:0]                        state;
  logic [3:0]                        state_next;
  logic [ips_pkg::OFS_W-1:0]         offset_col;
  logic [ips_pkg::OFS_W-1:0]         offset_row;
  logic                              out_valid;
  logic [ips_pkg::DATA_W-1:0]        out_value;
  logic                              out_last;

  logic signed [ips_pkg::COORD_W-1:0] cx;
  logic signed [ips_pkg::COORD_W-1:0] cy;
  logic [IW-1:0]                     xi;
  logic [IW-1:0]                     x1i;
  logic [IW-1:0]                     yi;
  logic [IW-1:0]                     y1i;
  logic signed [FXW-1:0]             fx;
  logic signed [FXW-1:0]             fy;
  logic [ips_pkg::DATA_W-1:0]        p00;
  logic [ips_pkg::DATA_W-1:0]        p10;
  logic signed [PLW-1:0]             prod_lo;
  logic signed [PHW-1:0]             prod_hi;
  logic signed [AW-1:0]              acc_a;
  logic signed [DW-1:0]              diff;
  logic signed [ACW-1:0]             acc;

  logic [ips_pkg::DATA_W-1:0]        mem [MEM_DEPTH];
  logic [ips_pkg::DATA_W-1:0]        rdata;
  logic [MW-1:0]                     raddr;
  logic [MW-1:0]                     waddr;
  logic                              mem_we;

  logic [IW-1:0]                     w_max;
  logic [IW-1:0]                     h_max;
  logic [ips_pkg::RAD_W-1:0]         r_eff;
  logic [ips_pkg::OFS_W-1:0]         span_m1;
  logic                              patch_done;
  logic                              out_free;
  logic                              emit;

  logic signed [3:0]                 ofs_c;
  logic signed [3:0]                 ofs_r;
  logic signed [PW-1:0]              px;
  logic signed [PW-1:0]              py;
  logic signed [PW:0]                vx;
  logic signed [PW:0]                vy;
  logic [IW-1:0]                     x_c;
  logic [IW-1:0]                     y_c;
  logic signed [FXW-1:0]             fx_c;
  logic signed [FXW-1:0]             fy_c;

  logic signed [PDW-1:0]             pix_diff;
  logic signed [PDW-1:0]             mul_a;
  logic signed [FXW-1:0]             mul_b;
  logic signed [PDW-1:0]             diff_lo;
  logic signed [HW-1:0]              diff_hi;
  logic signed [ACW-1:0]             rnd;
  logic [ips_pkg::DATA_W-1:0]        res;

  function automatic logic [IW-1:0] clamp_ix(
    input logic signed [PW:0] v,
    input logic [IW-1:0]      lim
  );
    logic [PW:0] t;
    t = $unsigned(v) >> FRAC_BITS;
    if (v[PW]) return '0;
    if (32'(t) > 32'(lim)) return lim;
    return IW'(t);
  endfunction

  function automatic logic [MW-1:0] addr_of(
    input logic [IW-1:0] row,
    input logic [IW-1:0] col
  );
    return MW'(32'(row) * MAX_WIDTH + 32'(col));
  endfunction

  // effective geometry
  always_comb begin
    if (cfg.image_width == '0) begin
      w_max = '0;
    end else if (int'(cfg.image_width) > MAX_WIDTH) begin
      w_max = IW'(MAX_WIDTH - 1);
    end else begin
      w_max = IW'(cfg.image_width - 7'd1);
    end
    if (cfg.image_height == '0) begin
      h_max = '0;
    end else if (int'(cfg.image_height) > MAX_HEIGHT) begin
      h_max = IW'(MAX_HEIGHT - 1);
    end else begin
      h_max = IW'(cfg.image_height - 7'd1);
    end
    if (int'(cfg.patch_radius) > MAX_RADIUS) begin
      r_eff = ips_pkg::RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = cfg.patch_radius;
    end
  end

  assign span_m1    = {r_eff, 1'b0};
  assign patch_done = (offset_col == span_m1) && (offset_row == span_m1);
  assign out_free   = !out_valid || results.ready;
  assign emit       = (state == ST_EMIT) && out_free;
  assign q_pop      = (state == ST_IDLE) && q_valid;
  assign mem_we     = q_pop && (q_item.req_type == ips_pkg::REQ_WRITE) && q_item.wr_ok;
  assign waddr      = MW'(32'(q_item.write_row) * MAX_WIDTH + 32'(q_item.write_col));

  // sample point and neighbor indices
  always_comb begin
    ofs_c = $signed({1'b0, offset_col}) - $signed({2'b00, r_eff});
    ofs_r = $signed({1'b0, offset_row}) - $signed({2'b00, r_eff});
    px    = PW'(cx) + (PW'(ofs_c) <<< FRAC_BITS);
    py    = PW'(cy) + (PW'(ofs_r) <<< FRAC_BITS);
    vx    = (PW + 1)'(px);
    vy    = (PW + 1)'(py);
    if (cfg.interp_mode == ips_pkg::MODE_NEAREST) begin
      vx = vx + (PW + 1)'(HALF);
      vy = vy + (PW + 1)'(HALF);
    end
    x_c  = clamp_ix(vx, w_max);
    y_c  = clamp_ix(vy, h_max);
    fx_c = $signed(FXW'(px)) -
           $signed({{(FXW - IW - FRAC_BITS){1'b0}}, x_c, {FRAC_BITS{1'b0}}});
    fy_c = $signed(FXW'(py)) -
           $signed({{(FXW - IW - FRAC_BITS){1'b0}}, y_c, {FRAC_BITS{1'b0}}});
  end

  always_comb begin
    case (state)
      ST_RD0:  raddr = addr_of(yi, xi);
      ST_RD1:  raddr = addr_of(yi, x1i);
      ST_RD2:  raddr = addr_of(y1i, xi);
      ST_RD3:  raddr = addr_of(y1i, x1i);
      default: raddr = addr_of(yi, xi);
    endcase
  end

  // shared multiplier: row blends by fx, then the column blend by fy (low half)
  always_comb begin
    pix_diff = $signed({1'b0, rdata}) -
               $signed({1'b0, (state == ST_RD2) ? p00 : p10});
    diff_lo  = $signed({1'b0, diff[15:0]});
    diff_hi  = diff[DW-1:16];
    mul_a    = (state == ST_MUL2) ? diff_lo : pix_diff;
    mul_b    = (state == ST_MUL2) ? fy : fx;
  end

  always_comb begin
    rnd = acc + ACW'(RND_HALF);
    if (cfg.interp_mode == ips_pkg::MODE_NEAREST) begin
      res = p00;
    end else if (rnd[ACW-1]) begin
      res = '0;
    end else if (|rnd[ACW-1:RND_POS+16]) begin
      res = {ips_pkg::DATA_W{1'b1}};
    end else begin
      res = rnd[RND_POS+15:RND_POS];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_item.req_type == ips_pkg::REQ_SAMPLE) state_next = ST_IDX;
      end
      ST_IDX:  state_next = ST_RD0;
      ST_RD0:  state_next = ST_RD1;
      ST_RD1: begin
        state_next = (cfg.interp_mode == ips_pkg::MODE_NEAREST) ? ST_EMIT : ST_RD2;
      end
      ST_RD2:  state_next = ST_RD3;
      ST_RD3:  state_next = ST_MUL1;
      ST_MUL1: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_ACC;
      ST_ACC:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = patch_done ? ST_IDLE : ST_IDX;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      offset_col <= '0;
      offset_row <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        if (offset_col == span_m1) begin
          offset_col <= '0;
          offset_row <= (offset_row == span_m1) ? '0 : offset_row + 1'b1;
        end else begin
          offset_col <= offset_col + 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= q_item.write_value;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cx <= q_item.x_coord;
          cy <= q_item.y_coord;
        end
      end
      ST_IDX: begin
        xi  <= x_c;
        yi  <= y_c;
        x1i <= (x_c == w_max) ? x_c : x_c + 1'b1;
        y1i <= (y_c == h_max) ? y_c : y_c + 1'b1;
        fx  <= fx_c;
        fy  <= fy_c;
      end
      ST_RD1:  p00 <= rdata;
      ST_RD2:  prod_lo <= mul_a * mul_b;
      ST_RD3: begin
        p10   <= rdata;
        acc_a <= $signed({{(AW - 16 - FRAC_BITS){1'b0}}, p00, {FRAC_BITS{1'b0}}}) +
                 AW'(prod_lo);
      end
      ST_MUL1: prod_lo <= mul_a * mul_b;
      ST_DIFF: begin
        diff <= $signed({{(DW - 16 - FRAC_BITS){1'b0}}, p10, {FRAC_BITS{1'b0}}}) +
                DW'(prod_lo) - DW'(acc_a);
      end
      ST_MUL2: begin
        prod_lo <= mul_a * mul_b;
        prod_hi <= diff_hi * fy;
      end
      ST_ACC: begin
        acc <= (ACW'(acc_a) <<< FRAC_BITS) + ACW'(prod_lo) + (ACW'(prod_hi) <<< 16);
      end
      ST_EMIT: begin
        if (emit) begin
          out_value <= res;
          out_last  <= patch_done;
        end
      end
      default: ;
    endcase
  end

  assign results.valid        = out_valid;
  assign results.sample_value = out_value;
  assign results.last_sample  = out_last;

  a_idle_offsets_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> offset_col == '0 && offset_row == '0)
    else $error("patch walk not rewound at idle");

  a_offsets_in_span: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> offset_col <= span_m1 && offset_row <= span_m1)
    else $error("patch offset beyond span");

  a_index_in_image: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD0 |-> xi <= w_max && x1i <= w_max && yi <= h_max && y1i <= h_max)
    else $error("neighbor index outside image");

  a_last_ends_patch: assert property (@(posedge clk) disable iff (rst)
    emit && patch_done |=> state == ST_IDLE)
    else $error("patch continues after last sample");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside emit");

endmodule

// File: bench/image_patch_sampler_tb.sv
module image_patch_sampler_tb;

  localparam int MAX_DIM     = 64;
  localparam int FRAC        = 8;
  localparam int MAX_RAD     = 3;
  localparam int ONE         = 1 << FRAC;
  localparam int HALF        = 1 << (FRAC - 1);
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [ips_pkg::DATA_W-1:0] value;
    logic                       last;
  } sample_t;

  // Mirror of the pixel store and registers; queues the samples each
  // accepted transaction should produce.
  class patch_tracker;
    logic [ips_pkg::DATA_W-1:0] pixels [0:MAX_DIM*MAX_DIM-1];
    bit                         filled [0:MAX_DIM*MAX_DIM-1];
    logic [ips_pkg::DIM_W-1:0]  width_reg  = ips_pkg::RST_IMAGE_WIDTH;
    logic [ips_pkg::DIM_W-1:0]  height_reg = ips_pkg::RST_IMAGE_HEIGHT;
    logic                       mode_reg   = ips_pkg::RST_INTERP_MODE;
    logic [ips_pkg::RAD_W-1:0]  radius_reg = ips_pkg::RST_PATCH_RADIUS;
    sample_t                    due_samples [$];
    int                         errors;
    int                         seen;

    function int eff_dim(logic [ips_pkg::DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function int trunc_q(int v);
      if (v >= 0) return v >>> FRAC;
      return -((-v) >>> FRAC);
    endfunction

    function int clip(int v, int n);
      if (v < 0) return 0;
      if (v >= n) return n - 1;
      return v;
    endfunction

    function longint pel(int row, int col);
      return longint'({48'd0, pixels[row*MAX_DIM + col]});
    endfunction

    function void set_reg(logic [ips_pkg::CFG_IDX_W-1:0] idx,
                          logic [ips_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        ips_pkg::CFG_IMAGE_WIDTH:  width_reg  = val[ips_pkg::DIM_W-1:0];
        ips_pkg::CFG_IMAGE_HEIGHT: height_reg = val[ips_pkg::DIM_W-1:0];
        ips_pkg::CFG_INTERP_MODE:  mode_reg   = val[0];
        ips_pkg::CFG_PATCH_RADIUS: radius_reg = val[ips_pkg::RAD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [ips_pkg::DATA_W-1:0] interp_point(int px, int py, int w, int h);
      int     x, y, x1, y1;
      longint fx, fy, gx, gy, acc;
      if (mode_reg == ips_pkg::MODE_NEAREST)
        return pixels[clip(trunc_q(py + HALF), h)*MAX_DIM +
                      clip(trunc_q(px + HALF), w)];
      x  = clip(trunc_q(px), w);
      y  = clip(trunc_q(py), h);
      fx = px - x * ONE;
      fy = py - y * ONE;
      x1 = clip(x + 1, w);
      y1 = clip(y + 1, h);
      gx = ONE - fx;
      gy = ONE - fy;
      acc = pel(y, x) * gx * gy + pel(y, x1) * fx * gy
          + pel(y1, x1) * fx * fy + pel(y1, x) * gx * fy;
      acc = acc + (longint'(1) <<< (2*FRAC - 1));
      if (acc < 0) return '0;
      acc = acc >>> (2*FRAC);
      if (acc > 65535) return '1;
      return acc[ips_pkg::DATA_W-1:0];
    endfunction

    function void note_item(logic rt, logic signed [ips_pkg::COORD_W-1:0] x, y,
                            logic [ips_pkg::POS_W-1:0] col, row,
                            logic [ips_pkg::DATA_W-1:0] val);
      int      w, h, r, cx, cy;
      sample_t s;
      if (rt == ips_pkg::REQ_WRITE) begin
        pixels[row*MAX_DIM + col] = val;
        filled[row*MAX_DIM + col] = 1'b1;
        return;
      end
      w  = eff_dim(width_reg);
      h  = eff_dim(height_reg);
      r  = int'(radius_reg);
      if (r > MAX_RAD) r = MAX_RAD;
      cx = int'(x);
      cy = int'(y);
      for (int dr = -r; dr <= r; dr++) begin
        for (int dc = -r; dc <= r; dc++) begin
          s.value = interp_point(cx + dc*ONE, cy + dr*ONE, w, h);
          s.last  = (dr == r) && (dc == r);
          due_samples.insert(due_samples.size(), s);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    task check_sample(logic [ips_pkg::DATA_W-1:0] value, logic last);
      sample_t want;
      seen++;
      if (due_samples.size() == 0) begin
        report($sformatf("result %0d: value %h with nothing expected", seen, value));
        return;
      end
      want = due_samples.pop_front();
      if (value !== want.value)
        report($sformatf("result %0d: sample_value %h, want %h", seen, value, want.value));
      if (last !== want.last)
        report($sformatf("result %0d: last_sample %b, want %b", seen, last, want.last));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we;
  logic [ips_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ips_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             cycles = 0;
  int                             stall_left = 0;
  bit                             in_steady = 1'b0;
  bit                             out_steady = 1'b0;

  ips_in_if  item_ch ();
  ips_out_if res_ch ();

  patch_tracker board = new();

  logic signed [ips_pkg::COORD_W-1:0] dir_x [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0180,
                                                    16'hFE00, 16'hFE00, 16'hFF80, 16'h0380};
  logic signed [ips_pkg::COORD_W-1:0] dir_y [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0080,
                                                    16'h0000, 16'h0100, 16'h0040, 16'h0280};

  image_patch_sampler #(
    .MAX_WIDTH(MAX_DIM),
    .MAX_HEIGHT(MAX_DIM),
    .FRAC_BITS(FRAC),
    .MAX_RADIUS(MAX_RAD)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .items(item_ch),
    .results(res_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int idle_len(int zero_pct);
    int k;
    k = $urandom_range(0, 99);
    if (k < zero_pct) return 0;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(1, 3);
    if (k < 92) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [ips_pkg::DATA_W-1:0] pick_value();
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) return '0;
    if (k < 20) return '1;
    return ips_pkg::DATA_W'($urandom);
  endfunction

  function automatic logic [ips_pkg::COORD_W-1:0] rand_coord(int n);
    int k, t;
    k = $urandom_range(0, 99);
    if (k < 15) return ips_pkg::COORD_W'($urandom);
    if (k < 30) begin
      t = $urandom_range(0, n + 1);
      return ips_pkg::COORD_W'((t - 1) * ONE);
    end
    t = $urandom_range(0, (n + 6) * ONE);
    return ips_pkg::COORD_W'(t - 3 * ONE);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (!out_steady && $urandom_range(0, 99) < 30) begin
      stall_left = idle_len(0) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready)
      board.note_item(item_ch.req_type, item_ch.x_coord, item_ch.y_coord,
                      item_ch.write_col, item_ch.write_row, item_ch.write_value);
    if (!rst && res_ch.valid && res_ch.ready)
      board.check_sample(res_ch.sample_value, res_ch.last_sample);
  end

  // valid stays high when the next transaction follows without a gap
  task automatic send_txn(logic rt, logic [ips_pkg::COORD_W-1:0] x, y,
                          logic [ips_pkg::POS_W-1:0] col, row,
                          logic [ips_pkg::DATA_W-1:0] val);
    int gap;
    gap = in_steady ? 0 : idle_len(50);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.req_type    <= rt;
    item_ch.x_coord     <= x;
    item_ch.y_coord     <= y;
    item_ch.write_col   <= col;
    item_ch.write_row   <= row;
    item_ch.write_value <= val;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic send_sample(logic [ips_pkg::COORD_W-1:0] x, y);
    send_txn(ips_pkg::REQ_SAMPLE, x, y, ips_pkg::POS_W'($urandom),
             ips_pkg::POS_W'($urandom), ips_pkg::DATA_W'($urandom));
  endtask

  task automatic send_pixel(int col, int row, logic [ips_pkg::DATA_W-1:0] val);
    send_txn(ips_pkg::REQ_WRITE, ips_pkg::COORD_W'($urandom), ips_pkg::COORD_W'($urandom),
             ips_pkg::POS_W'(col), ips_pkg::POS_W'(row), val);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [ips_pkg::CFG_IDX_W-1:0] idx,
                           logic [ips_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic configure(logic [ips_pkg::DIM_W-1:0] w, h, logic mode,
                           logic [ips_pkg::RAD_W-1:0] rad);
    write_reg(ips_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(ips_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(ips_pkg::CFG_INTERP_MODE, ips_pkg::CFG_DATA_W'(mode));
    write_reg(ips_pkg::CFG_PATCH_RADIUS, ips_pkg::CFG_DATA_W'(rad));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [ips_pkg::DIM_W-1:0] w, h, logic mode,
                           logic [ips_pkg::RAD_W-1:0] rad, int count);
    int ew, eh;
    drain();
    configure(w, h, mode, rad);
    ew = board.eff_dim(w);
    eh = board.eff_dim(h);
    in_steady  = ($urandom_range(0, 3) == 0);
    out_steady = ($urandom_range(0, 3) == 0);
    // every pixel a sample can reach must hold a value first
    for (int r = 0; r < eh; r++)
      for (int c = 0; c < ew; c++)
        if (!board.filled[r*MAX_DIM + c]) send_pixel(c, r, pick_value());
    repeat (count) begin
      if ($urandom_range(0, 99) < 25) begin
        if ($urandom_range(0, 1) == 0)
          send_pixel($urandom_range(0, ew - 1), $urandom_range(0, eh - 1), pick_value());
        else
          send_pixel($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                     pick_value());
      end else begin
        send_sample(rand_coord(ew), rand_coord(eh));
      end
    end
  endtask

  initial begin
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.req_type    <= ips_pkg::REQ_WRITE;
    item_ch.x_coord     <= '0;
    item_ch.y_coord     <= '0;
    item_ch.write_col   <= '0;
    item_ch.write_row   <= '0;
    item_ch.write_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // checkerboard of full-scale values so edge extrapolation saturates both ways
    configure(7'd4, 7'd3, ips_pkg::MODE_BILINEAR, 2'd0);
    send_pixel(MAX_DIM - 1, MAX_DIM - 1, '1);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        send_pixel(c, r, ((r + c) % 2 == 1) ? {ips_pkg::DATA_W{1'b1}}
                                            : {ips_pkg::DATA_W{1'b0}});
    foreach (dir_x[i]) send_sample(dir_x[i], dir_y[i]);
    drain();
    configure(7'd4, 7'd3, ips_pkg::MODE_NEAREST, 2'd3);
    send_sample(dir_x[0], dir_y[0]);
    send_sample(dir_x[3], dir_y[3]);
    send_sample(dir_x[6], dir_y[6]);
    drain();
    configure(7'd4, 7'd3, ips_pkg::MODE_BILINEAR, 2'd3);
    send_sample(16'h0140, 16'h00C0);

    run_phase(7'd0,   7'd0,   ips_pkg::MODE_BILINEAR, 2'd1, 18);
    run_phase(7'd127, 7'd1,   ips_pkg::MODE_NEAREST,  2'd2, 18);
    run_phase(7'd64,  7'd1,   ips_pkg::MODE_BILINEAR, 2'd3, 18);
    run_phase(7'd1,   7'd64,  ips_pkg::MODE_BILINEAR, 2'd0, 20);
    run_phase(7'd1,   7'd127, ips_pkg::MODE_NEAREST,  2'd1, 18);
    run_phase(7'd3,   7'd4,   ips_pkg::MODE_BILINEAR, 2'd2, 18);
    run_phase(7'd5,   7'd5,   ips_pkg::MODE_BILINEAR, 2'd1, 20);
    run_phase(7'd2,   7'd12,  ips_pkg::MODE_NEAREST,  2'd3, 18);
    run_phase(7'd33,  7'd1,   ips_pkg::MODE_BILINEAR, 2'd0, 20);
    run_phase(7'd65,  7'd1,   ips_pkg::MODE_BILINEAR, 2'd3, 16);
    run_phase(7'd6,   7'd6,   ips_pkg::MODE_NEAREST,  2'd0, 20);
    drain();

    if (board.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
